// ----- src/hkrt_pkg.sv -----
package hkrt_pkg;

    localparam int KEYS_DEF   = 64;
    localparam int TRAVEL_TOP = 32;

    localparam int KEY_W  = 6;
    localparam int RAW_W  = 8;
    localparam int LVL_W  = 6;
    localparam int DLT_W  = 8;
    localparam int CFG_AW = 2;
    localparam int CFG_DW = 8;

    // Register indexes on the configuration channel
    localparam logic [CFG_AW-1:0] CFG_RAPID_MODE      = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_ACTUATION_LEVEL = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_PRESS_DELTA     = 2'd2;
    localparam logic [CFG_AW-1:0] CFG_RELEASE_DELTA   = 2'd3;

    localparam logic [LVL_W-1:0] ACT_LEVEL_RST     = 6'd16;
    localparam logic [DLT_W-1:0] PRESS_DELTA_RST   = 8'd4;
    localparam logic [DLT_W-1:0] RELEASE_DELTA_RST = 8'd4;

    // Rising sensor ceilings; the first one not exceeded picks the level
    localparam logic [RAW_W-1:0] CEILINGS [0:TRAVEL_TOP] = '{
        8'd11,  8'd36,  8'd49,  8'd75,  8'd97,  8'd109, 8'd123, 8'd135,
        8'd153, 8'd158, 8'd170, 8'd177, 8'd187, 8'd193, 8'd200, 8'd205,
        8'd210, 8'd213, 8'd218, 8'd222, 8'd226, 8'd230, 8'd235, 8'd238,
        8'd240, 8'd242, 8'd246, 8'd247, 8'd249, 8'd250, 8'd251, 8'd252,
        8'd255
    };

    typedef struct packed {
        logic             down;
        logic [LVL_W-1:0] peak;
        logic [LVL_W-1:0] valley;
    } key_state_t;

    // Compares against the rising ceilings form a thermometer code; its
    // lowest set bit is one-hot and selects the level by a flat OR
    function automatic logic [LVL_W-1:0] to_travel(input logic [RAW_W-1:0] raw);
        logic [TRAVEL_TOP:0] not_above;
        logic [TRAVEL_TOP:0] first;
        logic [LVL_W-1:0]    level;
        level = '0;
        for (int i = 0; i <= TRAVEL_TOP; i++)
        begin
            not_above[i] = (raw <= CEILINGS[i]);
        end
        first = not_above & ~{not_above[TRAVEL_TOP-1:0], 1'b0};
        for (int i = 0; i <= TRAVEL_TOP; i++)
        begin
            if (first[i])
            begin
                level = level | LVL_W'(TRAVEL_TOP - i);
            end
        end
        return level;
    endfunction

endpackage

// ----- src/hall_key_rapid_trigger.sv -----
// Path: stage 1 registers, then the output register that drives m_tvalid.
// Throughput: one request per cycle unless m_tready stalls; the per-key state
// memory is read once and written once per cycle, last write forwarded to next item.
// Reset: rst_n is asynchronous, active low; it clears the pipeline, the
// configuration and the per-key valid bits at once, so no clearing pass.
module hall_key_rapid_trigger
    import hkrt_pkg::*;
#(
    parameter int KEYS = KEYS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [15:0]         s_tdata,     // [5:0] key, [13:6] raw, [15:14] zero

    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [15:0]         m_tdata,     // [5:0] key_out, [11:6] travel,
                                             // [12] pressed, [15:13] zero

    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CFG_AW-1:0]   cfg_index,
    input  logic [CFG_DW-1:0]   cfg_data
);

    localparam int IDX_W = (KEYS > 1) ? $clog2(KEYS) : 1;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic             rapid_mode_reg;
    logic [LVL_W-1:0] act_level_reg;
    logic [DLT_W-1:0] press_delta_reg;
    logic [DLT_W-1:0] release_delta_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rapid_mode_reg    <= 1'b0;
            act_level_reg     <= ACT_LEVEL_RST;
            press_delta_reg   <= PRESS_DELTA_RST;
            release_delta_reg <= RELEASE_DELTA_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_RAPID_MODE:      rapid_mode_reg    <= cfg_data[0];
                CFG_ACTUATION_LEVEL: act_level_reg     <= cfg_data[LVL_W-1:0];
                CFG_PRESS_DELTA:     press_delta_reg   <= cfg_data;
                CFG_RELEASE_DELTA:   release_delta_reg <= cfg_data;
                default:             ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake: stage 1 moves on when the output register is free
    // ------------------------------------------------------------------
    logic s1_valid_reg;
    logic out_valid_reg;
    logic out_free;
    logic advance;
    logic accept;

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = s1_valid_reg && out_free;
    assign s_tready = !s1_valid_reg || out_free;
    assign accept   = s_tvalid && s_tready;

    // ------------------------------------------------------------------
    // Input side: unpack, convert the raw byte, look up the key state
    // ------------------------------------------------------------------
    logic [KEY_W-1:0] in_key;
    logic [RAW_W-1:0] in_raw;
    logic [IDX_W-1:0] in_idx;

    assign in_key = s_tdata[KEY_W-1:0];
    assign in_raw = s_tdata[KEY_W+RAW_W-1:KEY_W];
    assign in_idx = IDX_W'(in_key);

    logic [KEY_W-1:0] s1_key_reg;
    logic [LVL_W-1:0] s1_travel_reg;
    logic             s1_in_range_reg;
    logic [IDX_W-1:0] s1_idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_key_reg      <= in_key;
            s1_travel_reg   <= to_travel(in_raw);
            s1_in_range_reg <= (32'(in_key) < KEYS);
            s1_idx_reg      <= in_idx;
        end
    end

    // Per-key state memory; entries with a clear valid bit read as reset
    key_state_t mem [KEYS];
    logic       entry_vld_reg [KEYS];
    key_state_t rd_data_reg;
    logic       rd_vld_reg;

    logic       wr_en;
    key_state_t wr_data;

    assign wr_en = advance && s1_in_range_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[s1_idx_reg] <= wr_data;
        end
        if (accept)
        begin
            rd_data_reg <= mem[in_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < KEYS; k++)
            begin
                entry_vld_reg[k] <= 1'b0;
            end
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                entry_vld_reg[s1_idx_reg] <= 1'b1;
            end
            if (accept)
            begin
                rd_vld_reg <= entry_vld_reg[in_idx];
            end
        end
    end

    // Last write, forwarded when the read at the same edge missed it
    logic             byp_valid_reg;
    logic [IDX_W-1:0] byp_idx_reg;
    key_state_t       byp_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_valid_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            byp_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            byp_idx_reg  <= s1_idx_reg;
            byp_data_reg <= wr_data;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: actuation / rapid-trigger update
    // ------------------------------------------------------------------
    key_state_t       cur;
    logic [LVL_W-1:0] s;
    logic [LVL_W-1:0] pk_new;
    logic [LVL_W-1:0] vl_new;
    logic             first_press;
    logic             repeat_press;
    logic             pressed_now;

    assign s = s1_travel_reg;

    always_comb
    begin
        priority if (byp_valid_reg && byp_idx_reg == s1_idx_reg)
        begin
            cur = byp_data_reg;
        end
        else if (rd_vld_reg)
        begin
            cur = rd_data_reg;
        end
        else
        begin
            cur.down   = 1'b0;
            cur.peak   = '0;
            cur.valley = LVL_W'(TRAVEL_TOP);
        end
    end

    always_comb
    begin
        wr_data      = cur;
        pk_new       = cur.peak;
        vl_new       = cur.valley;
        first_press  = 1'b0;
        repeat_press = 1'b0;
        if (!rapid_mode_reg)
        begin
            wr_data.down   = (s >= act_level_reg);
            wr_data.peak   = s;
            wr_data.valley = s;
        end
        else if (cur.down)
        begin
            // Track the peak; release after falling release_delta below it
            pk_new       = (s > cur.peak) ? s : cur.peak;
            wr_data.peak = pk_new;
            if ((9'(s) + 9'(release_delta_reg)) <= 9'(pk_new))
            begin
                wr_data.down   = 1'b0;
                wr_data.valley = s;
            end
        end
        else
        begin
            // Track the valley; a zero peak, as after reset, uses the absolute level
            vl_new         = (s < cur.valley) ? s : cur.valley;
            wr_data.valley = vl_new;
            first_press    = (cur.peak == '0) && (s >= act_level_reg);
            repeat_press   = (cur.peak != '0)
                             && (9'(s) >= (9'(vl_new) + 9'(press_delta_reg)));
            if (first_press || repeat_press)
            begin
                wr_data.down = 1'b1;
                wr_data.peak = s;
            end
        end
    end

    assign pressed_now = s1_in_range_reg && wr_data.down;

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic [KEY_W-1:0] out_key_reg;
    logic [LVL_W-1:0] out_travel_reg;
    logic             out_pressed_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_key_reg     <= s1_key_reg;
            out_travel_reg  <= s;
            out_pressed_reg <= pressed_now;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_pressed_reg, out_travel_reg, out_key_reg};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_travel_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (out_travel_reg <= LVL_W'(TRAVEL_TOP)))
        else $error("travel level above top");

    a_advance_shows: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> m_tvalid)
        else $error("advanced item not presented");

    a_plain_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !rapid_mode_reg && (32'(out_key_reg) < KEYS))
        |-> (out_pressed_reg == (out_travel_reg >= act_level_reg)))
        else $error("plain mode pressed flag wrong");

    a_out_of_range: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (32'(out_key_reg) >= KEYS)) |-> !out_pressed_reg)
        else $error("key beyond range reported pressed");

endmodule

// ----- tb/key_report_checker.sv -----
`timescale 1ns / 100ps

module key_report_checker
    import hkrt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [15:0]       s_tdata,
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [15:0]       m_tdata,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [CFG_AW-1:0] cfg_index,
    input  logic [CFG_DW-1:0] cfg_data,
    output int                mismatches,
    output int                outstanding
);

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [LVL_W-1:0] travel;
        logic             pressed;
    } key_report_t;

    key_report_t expected_reports [$];
    key_report_t want;
    key_report_t seen;

    // Shadow copy of the settings and of the per-key state
    logic             rapid_on;
    logic [LVL_W-1:0] act_level;
    logic [DLT_W-1:0] rise_needed;
    logic [DLT_W-1:0] fall_needed;

    logic             down_q   [0:KEYS_DEF-1];
    logic [LVL_W-1:0] peak_q   [0:KEYS_DEF-1];
    logic [LVL_W-1:0] valley_q [0:KEYS_DEF-1];

    function automatic int travel_of(input logic [RAW_W-1:0] raw);
        for (int i = 0; i <= TRAVEL_TOP; i++)
        begin
            if (raw <= CEILINGS[i])
            begin
                return TRAVEL_TOP - i;
            end
        end
        return 0;
    endfunction

    task automatic predict_report(input logic [KEY_W-1:0] k, input logic [RAW_W-1:0] raw,
                                  output key_report_t rep);
        int   s;
        int   pk;
        int   vl;
        logic dn;
        s  = travel_of(raw);
        dn = 1'b0;
        if (k < KEYS_DEF)
        begin
            pk = peak_q[k];
            vl = valley_q[k];
            dn = down_q[k];
            if (!rapid_on)
            begin
                dn = (s >= int'(act_level));
                pk = s;
                vl = s;
            end
            else if (dn)
            begin
                if (s > pk)
                begin
                    pk = s;
                end
                if (s + int'(fall_needed) <= pk)
                begin
                    dn = 1'b0;
                    vl = s;
                end
            end
            else
            begin
                if (s < vl)
                begin
                    vl = s;
                end
                // a zero peak, as after reset, uses the absolute level
                if ((pk == 0 && s >= int'(act_level)) ||
                    (pk != 0 && s >= vl + int'(rise_needed)))
                begin
                    dn = 1'b1;
                    pk = s;
                end
            end
            down_q[k]   = dn;
            peak_q[k]   = pk[LVL_W-1:0];
            valley_q[k] = vl[LVL_W-1:0];
        end
        rep.key     = k;
        rep.travel  = s[LVL_W-1:0];
        rep.pressed = dn;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rapid_on    = 1'b0;
            act_level   = ACT_LEVEL_RST;
            rise_needed = PRESS_DELTA_RST;
            fall_needed = RELEASE_DELTA_RST;
            for (int k = 0; k < KEYS_DEF; k++)
            begin
                down_q[k]   = 1'b0;
                peak_q[k]   = '0;
                valley_q[k] = LVL_W'(TRAVEL_TOP);
            end
            expected_reports.delete();
            mismatches  = 0;
            outstanding = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_RAPID_MODE:      rapid_on    = cfg_data[0];
                    CFG_ACTUATION_LEVEL: act_level   = cfg_data[LVL_W-1:0];
                    CFG_PRESS_DELTA:     rise_needed = cfg_data;
                    CFG_RELEASE_DELTA:   fall_needed = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
            begin
                predict_report(s_tdata[5:0], s_tdata[13:6], want);
                expected_reports.push_back(want);
            end
            if (m_tvalid && m_tready)
            begin
                seen = {m_tdata[5:0], m_tdata[11:6], m_tdata[12]};
                if (expected_reports.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("%0t: unexpected result key=%0d travel=%0d pressed=%0d",
                                 $realtime, seen.key, seen.travel, seen.pressed);
                    end
                end
                else
                begin
                    want = expected_reports.pop_front();
                    if (seen.key != want.key || seen.travel != want.travel ||
                        seen.pressed != want.pressed)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("%0t: mismatch exp key=%0d travel=%0d pressed=%0d, %s%0d %s%0d %s%0d",
                                     $realtime, want.key, want.travel, want.pressed,
                                     "got key=", seen.key, "travel=", seen.travel,
                                     "pressed=", seen.pressed);
                        end
                    end
                end
            end
            outstanding = expected_reports.size();
        end
    end

endmodule

// ----- tb/hall_key_rapid_trigger_tb.sv -----
`timescale 1ns / 100ps

// Stimulus and verdict for the hall key rapid trigger block. The checker
// beside the DUT tracks settings and per-key state and scores every result.
module hall_key_rapid_trigger_tb;
    import hkrt_pkg::*;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [15:0]       s_tdata   = '0;    // [5:0] key, [13:6] raw
    logic              m_tvalid;
    logic              m_tready  = 1'b1;
    logic [15:0]       m_tdata;           // [5:0] key_out, [11:6] travel, [12] pressed
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [CFG_AW-1:0] cfg_index = '0;
    logic [CFG_DW-1:0] cfg_data  = '0;

    int mismatches;
    int outstanding;

    // Pacing knobs, percent of cycles
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    int samples_sent     = 0;
    int settings_applied = 0;

    // Per-key finger position used to build smooth press/release strokes
    int finger_travel [0:KEYS_DEF-1];

    always #1 clk = ~clk;

    hall_key_rapid_trigger DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    key_report_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // Receiver backpressure
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // One sensor sample request; valid stays up afterwards so back-to-back
    // requests need no drop in between.
    task automatic send_sample(input logic [KEY_W-1:0] k, input logic [RAW_W-1:0] raw);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, raw, k};
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        samples_sent++;
    endtask

    // Hold the sender off until every outstanding result is back.
    // Checked on the falling edge so the checker has settled.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do
        begin
            @(negedge clk);
        end
        while (outstanding != 0);
        @(posedge clk);
    endtask

    task automatic put_register(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
    endtask

    // Block is idle once drained: one result per request, nothing hidden
    task automatic apply_settings(input logic rapid, input int act, input int rise, input int fall);
        drain_results();
        put_register(CFG_RAPID_MODE, {7'd0, rapid});
        put_register(CFG_ACTUATION_LEVEL, CFG_DW'(act));
        put_register(CFG_PRESS_DELTA, CFG_DW'(rise));
        put_register(CFG_RELEASE_DELTA, CFG_DW'(fall));
        cfg_valid <= 1'b0;
        settings_applied++;
    endtask

    // Pick a raw byte anywhere inside the band that maps to this travel
    function automatic logic [RAW_W-1:0] raw_for_travel(input int t);
        int idx;
        int lo;
        idx = TRAVEL_TOP - t;
        lo  = (idx == 0) ? 0 : int'(CEILINGS[idx-1]) + 1;
        return RAW_W'($urandom_range(int'(CEILINGS[idx]), lo));
    endfunction

    task automatic random_sample();
        int k;
        int step;
        if ($urandom_range(0, 99) < 15)
        begin
            // noise: any key, any byte
            send_sample(KEY_W'($urandom_range(0, 63)), RAW_W'($urandom_range(0, 255)));
        end
        else
        begin
            // smooth strokes on a few hot keys so rapid trigger sees real motion
            k = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 3) : $urandom_range(0, 63);
            if ($urandom_range(0, 9) == 0)
            begin
                finger_travel[k] = ($urandom_range(0, 1) == 1) ? TRAVEL_TOP : 0;
            end
            else
            begin
                step = $urandom_range(0, 16) - 8;
                finger_travel[k] += step;
                if (finger_travel[k] < 0)
                begin
                    finger_travel[k] = 0;
                end
                if (finger_travel[k] > TRAVEL_TOP)
                begin
                    finger_travel[k] = TRAVEL_TOP;
                end
            end
            send_sample(KEY_W'(k), raw_for_travel(finger_travel[k]));
        end
    endtask

    initial
    begin
        for (int k = 0; k < KEYS_DEF; k++)
        begin
            finger_travel[k] = 0;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: plain mode at reset settings, byte extremes, band edges
        send_sample(6'd0, 8'd0);
        send_sample(6'd63, 8'd255);
        send_sample(6'd1, 8'd11);
        send_sample(6'd1, 8'd12);
        send_sample(6'd2, 8'd252);
        send_sample(6'd2, 8'd253);
        send_sample(6'd42, 8'hAA);
        send_sample(6'd21, 8'h55);

        // Rapid trigger: first press, release by delta, re-press by delta
        apply_settings(1'b1, 16, 4, 4);
        send_sample(6'd5, 8'd255);
        send_sample(6'd5, 8'd0);
        send_sample(6'd5, 8'd200);
        send_sample(6'd5, 8'd170);
        send_sample(6'd9, 8'd210);

        // Actuation at zero: a press at travel 0 keeps peak 0, so the next
        // press again goes by the absolute level
        apply_settings(1'b1, 0, 4, 0);
        send_sample(6'd6, 8'd255);
        send_sample(6'd6, 8'd255);
        send_sample(6'd6, 8'd255);

        // Actuation above the top can never be reached
        apply_settings(1'b1, 33, 4, 4);
        send_sample(6'd7, 8'd0);
        apply_settings(1'b0, 63, 4, 4);
        send_sample(6'd8, 8'd0);

        // Random part: eight phases, each with its own settings and pacing
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: apply_settings(1'b0, 16, 4, 4);
                1: apply_settings(1'b1, 16, 4, 4);
                2: apply_settings(1'b1, 32, 0, 0);
                3: apply_settings(1'b1, 0, 255, 255);
                4: apply_settings(1'b0, 63, 0, 255);
                5: apply_settings(1'b1, 8, 2, 6);
                6: apply_settings(1'b1, $urandom_range(0, 40), $urandom_range(0, 12),
                                  $urandom_range(0, 12));
                default: apply_settings(1'b1, 20, 1, 1);
            endcase
            case (ph % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 55;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 55;
                end
                default:
                begin
                    send_idle_pct  = 38;
                    recv_stall_pct = 38;
                end
            endcase
            for (int n = 0; n < 50; n++)
            begin
                // one full stop mid-phase: sender waits for every result
                if (ph == 5 && n == 25)
                begin
                    drain_results();
                end
                random_sample();
            end
        end

        drain_results();
        recv_stall_pct = 0;
        repeat (8) @(posedge clk);

        $display("Covered %0d sensor samples across %0d register settings,", samples_sent,
                 settings_applied);
        $display("plain and rapid modes, delta and level extremes, four pacing mixes.");
        if (mismatches == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial
    begin
        #200000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
